### rtl/core/pss_pkg.sv
// Shared types, control-word layout and microcode constants for the plucked-string synth.
package pss_pkg;

    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int COND_W = 4;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_LATCH    = 4'd1;
    localparam logic [OP_W-1:0] OP_SETUP    = 4'd2;
    localparam logic [OP_W-1:0] OP_OUT_CUR  = 4'd3;
    localparam logic [OP_W-1:0] OP_TAP      = 4'd4;
    localparam logic [OP_W-1:0] OP_TAP_END  = 4'd5;
    localparam logic [OP_W-1:0] OP_DIV_SUM  = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV_CUR  = 4'd7;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd8;
    localparam logic [OP_W-1:0] OP_WRBACK   = 4'd9;
    localparam logic [OP_W-1:0] OP_LOAD_WR  = 4'd10;
    localparam logic [OP_W-1:0] OP_OUT_ZERO = 4'd11;

    // Jump conditions
    localparam logic [COND_W-1:0] C_NONE      = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
    localparam logic [COND_W-1:0] C_NO_ITEM   = 4'd2;
    localparam logic [COND_W-1:0] C_LOAD      = 4'd3;
    localparam logic [COND_W-1:0] C_ZERO_PER  = 4'd4;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 4'd5;
    localparam logic [COND_W-1:0] C_MODE1     = 4'd6;
    localparam logic [COND_W-1:0] C_NO_TAPS   = 4'd7;
    localparam logic [COND_W-1:0] C_MORE_TAPS = 4'd8;
    localparam logic [COND_W-1:0] C_DIV_BUSY  = 4'd9;

    // Microprogram addresses
    localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] S_DISP    = 4'd1;
    localparam logic [STEP_W-1:0] S_PERCHK  = 4'd2;
    localparam logic [STEP_W-1:0] S_SETUP   = 4'd3;
    localparam logic [STEP_W-1:0] S_CUR     = 4'd4;
    localparam logic [STEP_W-1:0] S_MODECHK = 4'd5;
    localparam logic [STEP_W-1:0] S_TAPCHK  = 4'd6;
    localparam logic [STEP_W-1:0] S_TAP     = 4'd7;
    localparam logic [STEP_W-1:0] S_TAP_END = 4'd8;
    localparam logic [STEP_W-1:0] S_DIVSUM  = 4'd9;
    localparam logic [STEP_W-1:0] S_DIVCUR  = 4'd10;
    localparam logic [STEP_W-1:0] S_DIV     = 4'd11;
    localparam logic [STEP_W-1:0] S_WRBACK  = 4'd12;
    localparam logic [STEP_W-1:0] S_LOAD    = 4'd13;
    localparam logic [STEP_W-1:0] S_SILENT  = 4'd14;
    localparam logic [STEP_W-1:0] S_RETURN  = 4'd15;

    // Register indexes
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_RATE   = 2'd2;

    localparam logic [12:0] PERIOD_RESET = 13'd0;
    localparam logic        MODE_RESET   = 1'b0;
    localparam logic [15:0] RATE_RESET   = 16'd512;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic is_load;
        logic zero_per;
        logic out_busy;
        logic mode1;
        logic no_taps;
        logic more_taps;
        logic div_busy;
    } stat_t;

    typedef struct packed {
        logic [12:0] period_length;
        logic        decay_mode;
        logic [15:0] decay_rate;
    } cfg_t;

endpackage

### rtl/core/pss_seq.sv
// Microprogram sequencer: step counter, control ROM and conditional jumps.
module pss_seq
    import pss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  in_ready
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              take;

    function automatic ctrl_t rom(input logic [STEP_W-1:0] s);
        ctrl_t w;
        unique case (s)
            S_IDLE:    w = '{OP_LATCH,    C_NO_ITEM,   S_IDLE};
            S_DISP:    w = '{OP_NOP,      C_LOAD,      S_LOAD};
            S_PERCHK:  w = '{OP_NOP,      C_ZERO_PER,  S_SILENT};
            S_SETUP:   w = '{OP_SETUP,    C_NONE,      S_IDLE};
            S_CUR:     w = '{OP_OUT_CUR,  C_OUT_BUSY,  S_CUR};
            S_MODECHK: w = '{OP_NOP,      C_MODE1,     S_DIVCUR};
            S_TAPCHK:  w = '{OP_NOP,      C_NO_TAPS,   S_TAP_END};
            S_TAP:     w = '{OP_TAP,      C_MORE_TAPS, S_TAP};
            S_TAP_END: w = '{OP_TAP_END,  C_NONE,      S_IDLE};
            S_DIVSUM:  w = '{OP_DIV_SUM,  C_ALWAYS,    S_DIV};
            S_DIVCUR:  w = '{OP_DIV_CUR,  C_NONE,      S_IDLE};
            S_DIV:     w = '{OP_DIV_STEP, C_DIV_BUSY,  S_DIV};
            S_WRBACK:  w = '{OP_WRBACK,   C_ALWAYS,    S_IDLE};
            S_LOAD:    w = '{OP_LOAD_WR,  C_ALWAYS,    S_IDLE};
            S_SILENT:  w = '{OP_OUT_ZERO, C_OUT_BUSY,  S_SILENT};
            S_RETURN:  w = '{OP_NOP,      C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl     = rom(step_reg);
    assign in_ready = (step_reg == S_IDLE);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NONE:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ITEM:   take = !stat.in_valid;
            C_LOAD:      take = stat.is_load;
            C_ZERO_PER:  take = stat.zero_per;
            C_OUT_BUSY:  take = stat.out_busy;
            C_MODE1:     take = stat.mode1;
            C_NO_TAPS:   take = stat.no_taps;
            C_MORE_TAPS: take = stat.more_taps;
            C_DIV_BUSY:  take = stat.div_busy;
            default:     take = 1'b0;
        endcase
        step_next = take ? ctrl.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### rtl/core/pss_datapath.sv
// Datapath: delay line memory, pointers, tap accumulator, serial divider, output register.
module pss_datapath
    import pss_pkg::*;
#(
    parameter int MAX_PERIOD  = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic        in_op,
    input  logic [15:0] in_noise,
    output stat_t       stat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_sample
);

    localparam int SB  = SAMPLE_BITS;
    localparam int AW  = $clog2(MAX_PERIOD);
    localparam int EW  = $clog2(MAX_PERIOD + 1);
    localparam int SW  = SB + 8;
    localparam int NW  = SB + 16;
    localparam int CW  = $clog2(NW + 1);
    localparam int SMAX = (1 << (SB - 1)) - 1;
    localparam int SMIN = -(1 << (SB - 1));

    localparam logic [NW-1:0] POS_LIM = {{(NW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic [NW-1:0] NEG_LIM = POS_LIM + 1'b1;
    localparam logic [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

    logic [SB-1:0] mem [MAX_PERIOD];

    // Control state
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] lp_reg, lp_next;
    logic [AW-1:0] pp_reg, pp_next;

    // Payload
    logic                 op_reg, op_next;
    logic [15:0]          noise_reg, noise_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [7:0]           cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic signed [SW-1:0] acc_reg, acc_next;
    logic [SB-1:0]        cur_reg, cur_next;
    logic [NW-1:0]        q_reg, q_next;
    logic [15:0]          rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        dcnt_reg, dcnt_next;
    logic [15:0]          out_data_reg, out_data_next;
    logic [SB-1:0]        rdata_reg;

    logic [EW-1:0]        per_eff;
    logic [AW-1:0]        pos_eff;
    logic [AW-1:0]        lp_eff;
    logic [15:0]          rate_eff;
    logic                 busy;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [SB-1:0]        wr_data;
    logic [16:0]          div_sh;
    logic                 div_ge;
    logic signed [NW-1:0] num;
    logic [SB-1:0]        noise_clamped;
    logic [SB-1:0]        quot_sat;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [EW-1:0] per);
        logic [EW-1:0] n;
        n = EW'(p) + 1'b1;
        return (n >= per) ? '0 : n[AW-1:0];
    endfunction

    function automatic logic [SB-1:0] clamp_noise(input logic [15:0] raw);
        logic signed [31:0] v;
        v = 32'(signed'(raw));
        if (v > SMAX)
        begin
            v = SMAX;
        end
        else if (v < SMIN)
        begin
            v = SMIN;
        end
        return v[SB-1:0];
    endfunction

    assign per_eff  = (32'(cfg.period_length) > MAX_PERIOD) ? EW'(MAX_PERIOD)
                                                              : EW'(cfg.period_length);
    assign pos_eff  = (EW'(pp_reg) < per_eff) ? pp_reg : '0;
    assign lp_eff   = (EW'(lp_reg) < per_eff) ? lp_reg : '0;
    assign rate_eff = (cfg.decay_rate == 16'd0) ? 16'd1 : cfg.decay_rate;
    assign busy     = out_valid_reg && !out_ready;

    assign noise_clamped = clamp_noise(noise_reg);

    assign div_sh = {rem_reg, q_reg[NW-1]};
    assign div_ge = (div_sh >= {1'b0, rate_eff});

    always_comb
    begin
        if (neg_reg)
        begin
            quot_sat = (q_reg > NEG_LIM) ? SAT_MIN : SB'(-q_reg);
        end
        else
        begin
            quot_sat = (q_reg > POS_LIM) ? SAT_MAX : q_reg[SB-1:0];
        end
    end

    always_comb
    begin
        if (ctrl.op == OP_DIV_SUM)
        begin
            num = {acc_reg, 8'd0};
        end
        else
        begin
            num = {{8{cur_reg[SB-1]}}, cur_reg, 8'd0};
        end
    end

    assign stat.in_valid  = in_valid;
    assign stat.is_load   = !op_reg;
    assign stat.zero_per  = (per_eff == '0);
    assign stat.out_busy  = busy;
    assign stat.mode1     = cfg.decay_mode;
    assign stat.no_taps   = (cnt_reg == 8'd0);
    assign stat.more_taps = (cnt_reg != 8'd1);
    assign stat.div_busy  = (dcnt_reg != CW'(1));

    assign rd_en   = (ctrl.op == OP_SETUP) || (ctrl.op == OP_TAP);
    assign rd_addr = (ctrl.op == OP_SETUP) ? pos_eff : idx_reg;
    assign wr_en   = (ctrl.op == OP_LOAD_WR) || (ctrl.op == OP_WRBACK);
    assign wr_addr = (ctrl.op == OP_LOAD_WR) ? lp_eff : pos_reg;
    assign wr_data = (ctrl.op == OP_LOAD_WR) ? noise_clamped : quot_sat;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        lp_next        = lp_reg;
        pp_next        = pp_reg;
        op_next        = op_reg;
        noise_next     = noise_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        cur_next       = cur_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        dcnt_next      = dcnt_reg;
        out_data_next  = out_data_reg;
        unique case (ctrl.op)
            OP_LATCH:
            begin
                op_next    = in_op;
                noise_next = in_noise;
            end
            OP_SETUP:
            begin
                pos_next  = pos_eff;
                idx_next  = pos_eff;
                cnt_next  = rate_eff[15:8];
                pend_next = 1'b0;
                acc_next  = '0;
            end
            OP_OUT_CUR:
            begin
                cur_next = rdata_reg;
                if (!busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 16'(32'(signed'(rdata_reg)));
                end
            end
            OP_OUT_ZERO:
            begin
                if (!busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 16'd0;
                end
            end
            OP_TAP:
            begin
                idx_next  = wrap_inc(idx_reg, per_eff);
                cnt_next  = cnt_reg - 8'd1;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    acc_next = acc_reg + SW'(signed'(rdata_reg));
                end
            end
            OP_TAP_END:
            begin
                pend_next = 1'b0;
                if (pend_reg)
                begin
                    acc_next = acc_reg + SW'(signed'(rdata_reg));
                end
            end
            OP_DIV_SUM, OP_DIV_CUR:
            begin
                neg_next  = num[NW-1];
                q_next    = num[NW-1] ? NW'(-num) : NW'(num);
                rem_next  = 16'd0;
                dcnt_next = CW'(NW);
            end
            OP_DIV_STEP:
            begin
                rem_next  = div_ge ? 16'(div_sh - {1'b0, rate_eff}) : div_sh[15:0];
                q_next    = {q_reg[NW-2:0], div_ge};
                dcnt_next = dcnt_reg - 1'b1;
            end
            OP_WRBACK:
            begin
                pp_next = wrap_inc(pos_reg, per_eff);
            end
            OP_LOAD_WR:
            begin
                lp_next = wrap_inc(lp_eff, per_eff);
                pp_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            lp_reg        <= '0;
            pp_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            lp_reg        <= lp_next;
            pp_reg        <= pp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        noise_reg    <= noise_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        pend_reg     <= pend_next;
        acc_reg      <= acc_next;
        cur_reg      <= cur_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        dcnt_reg     <= dcnt_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_data_reg;

endmodule

### rtl/core/plucked_string_synth.sv
// Top level of the plucked-string synthesizer: config registers, sequencer and datapath.
//
// Input stream (s_axis): tuser = operation (0 load, 1 play), tdata = noise sample.
// A load transaction writes one excitation sample at the load pointer and
// restarts playback at the start of the line; it gives no output.
// A play transaction gives one output transaction on m_axis (tdata = sample),
// then writes the decayed value back into the delay line, unless period is 0.
// Config channel: cfg_index selects period_length (0), decay_mode (1) or
// decay_rate (2); cfg_ready is always high. Write only while the block is idle.
// One item is processed at a time; s_axis_tready is high only while the
// microprogram waits at its idle step.
// Modes: divide mode divides the current sample; average mode first sums
// taps delay line reads, where taps is decay_rate[15:8] (one delay line read
// per cycle), and divides the sum. A play then runs NW = SAMPLE_BITS + 16
// restoring divider steps.
// The output register holds a result until m_axis_tready; the next play
// waits at its output step while that register is still full.
// Reset clears pointers and output valid and returns config to its reset
// values; delay line contents are undefined until loaded.
module plucked_string_synth
    import pss_pkg::*;
#(
    parameter int MAX_PERIOD  = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] noise_sample
    input  logic        s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PERIOD: cfg_next.period_length = cfg_data[12:0];
                REG_MODE:   cfg_next.decay_mode    = cfg_data[0];
                REG_RATE:   cfg_next.decay_rate    = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{PERIOD_RESET, MODE_RESET, RATE_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pss_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (s_axis_tready)
    );

    pss_datapath #(
        .MAX_PERIOD  (MAX_PERIOD),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_op      (s_axis_tuser),
        .in_noise   (s_axis_tdata),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (m_axis_tdata)
    );

endmodule

### rtl/core/pss_checker.sv
// Port-level checker for the plucked-string synth, bound to the top level.
module pss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // Stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // A new result only appears while an item is in progress
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready)
        else $error("result appeared while idle");

endmodule

bind plucked_string_synth pss_checker u_pss_checker (.*);
